>>> design/tpam_pkg.sv
// Package of the touch point averaging, mapping and debounce block.
// Holds widths, reset values, register indexes, the averaging reciprocal and the divider types.
// Depends on nothing; the divider and the top level use it.
package tpam_pkg;

    localparam int unsigned SAMPLES_PER_READ = 5;

    localparam int unsigned RAW_W      = 12;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned SCR_W      = 10;
    localparam int unsigned SIZE_W     = 11;
    localparam int unsigned DEB_W      = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned DIVD_W = RAW_W + SCR_W + 1;
    localparam int unsigned DIVR_W = RAW_W;
    localparam int unsigned DIVC_W = $clog2(DIVD_W);

    // The average is the burst sum times a rounded-up reciprocal, shifted right.
    // The shift is wide enough that the quotient is exact for every sum.
    localparam int unsigned AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_READ);
    localparam int unsigned RECIP_W   = SUM_W + 1;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'(((1 << AVG_SHIFT) + SAMPLES_PER_READ - 1) / SAMPLES_PER_READ);

    localparam logic [RAW_W-1:0]  X_RAW_LOW_RST  = 12'd280;
    localparam logic [RAW_W-1:0]  X_RAW_HIGH_RST = 12'd3860;
    localparam logic [RAW_W-1:0]  Y_RAW_LOW_RST  = 12'd320;
    localparam logic [RAW_W-1:0]  Y_RAW_HIGH_RST = 12'd3860;
    localparam logic [SIZE_W-1:0] WIDTH_RST      = 11'd320;
    localparam logic [SIZE_W-1:0] HEIGHT_RST     = 11'd240;
    localparam logic [RAW_W-1:0]  FLOOR_RST      = 12'd100;
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 16'd200;
    localparam logic [SIZE_W-1:0] SIZE_MAX       = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_FLOOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd7;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> design/tpam_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on tpam_pkg for widths and the request and response structs.
module tpam_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpam_pkg::t_div_req  i_req,
    output tpam_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [tpam_pkg::DIVC_W-1:0]   r_cnt;
    logic [tpam_pkg::DIVR_W-1:0]   r_rem;
    logic [tpam_pkg::DIVR_W-1:0]   r_dvs;
    logic [tpam_pkg::DIVD_W-1:0]   r_quo;

    logic [tpam_pkg::DIVR_W:0]     w_trial;
    logic [tpam_pkg::DIVR_W:0]     w_diff;
    logic                          w_fit;
    logic [tpam_pkg::DIVR_W-1:0]   n_rem;

    assign w_trial = {r_rem, r_quo[tpam_pkg::DIVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_fit ? w_diff[tpam_pkg::DIVR_W-1:0] : w_trial[tpam_pkg::DIVR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= tpam_pkg::DIVC_W'(tpam_pkg::DIVD_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[tpam_pkg::DIVD_W-2:0], w_fit};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> design/touch_point_average_map_debounce_unit.sv
// Top level: touch sample averaging, calibration mapping and tap debounce.
// Depends on tpam_pkg and on the shared divider tpam_div.
// A pair inside a burst is summed in the idle state; a pen-up result goes straight to emit.
// The last pair's result is averaged and, unless an average is under the floor, mapped by
// two 23-step passes through the shared divider for the axis mappings before the tap check.
// Inputs are refused until the output register takes the result; reset is synchronous, active low.
module touch_point_average_map_debounce_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpam_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tpam_pkg::RAW_W-1:0]        i_sample_x,
    input  logic [tpam_pkg::RAW_W-1:0]        i_sample_y,
    input  logic                              i_pen_down,
    input  logic [tpam_pkg::TIME_W-1:0]       i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_pressed,
    output logic                              o_tapped,
    output logic [tpam_pkg::SCR_W-1:0]        o_screen_x,
    output logic [tpam_pkg::SCR_W-1:0]        o_screen_y,
    output logic [tpam_pkg::RAW_W-1:0]        o_avg_x,
    output logic [tpam_pkg::RAW_W-1:0]        o_avg_y
);

    localparam int unsigned RW = tpam_pkg::RAW_W;
    localparam int unsigned SW = tpam_pkg::SCR_W;
    localparam int unsigned VW = tpam_pkg::DIVD_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_AVG_X, S_AVG_Y, S_CHECK,
        S_MUL, S_MAP_GO, S_MAP_WAIT, S_TAP, S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic                            r_axis, n_axis;
    logic [tpam_pkg::SUM_W-1:0]      r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [tpam_pkg::CNT_W-1:0]      r_count, n_count;
    logic [tpam_pkg::TIME_W-1:0]     r_last, n_last, r_now, n_now;
    logic [RW-1:0]                   r_ax, n_ax, r_ay, n_ay;
    logic [SW-1:0]                   r_px, n_px, r_py, n_py;
    logic                            r_pressed, n_pressed, r_tap, n_tap;
    logic [tpam_pkg::DIVD_W-1:0]     r_prod, n_prod;
    logic [RW-1:0]                   r_span, n_span;
    logic                            r_neg, n_neg, r_zero, n_zero;

    logic [RW-1:0]                   r_x_lo, r_x_hi, r_y_lo, r_y_hi, r_floor;
    logic [tpam_pkg::SIZE_W-1:0]     r_width, r_height;
    logic [tpam_pkg::DEB_W-1:0]      r_deb;

    logic                            r_out_valid, n_out_valid;
    logic                            r_o_pressed, r_o_tapped;
    logic [SW-1:0]                   r_o_px, r_o_py;
    logic [RW-1:0]                   r_o_ax, r_o_ay;

    tpam_pkg::t_div_req              w_req;
    tpam_pkg::t_div_rsp              w_rsp;

    logic                            w_accept, w_out_free, w_load_out;
    logic [tpam_pkg::CNT_W:0]        w_count_inc;
    logic [tpam_pkg::SUM_W-1:0]      w_avg_sum;
    logic [tpam_pkg::SUM_W+tpam_pkg::RECIP_W-1:0] w_avg_prod;
    logic [RW-1:0]                   w_avg;
    logic [SW-1:0]                   w_wm1, w_hm1;
    logic [RW-1:0]                   m_raw, m_lo, m_hi;
    logic [SW-1:0]                   m_dm, m_base;
    logic                            m_delta_neg;
    logic [RW:0]                     w_diff, w_diff_abs, w_span, w_span_abs;
    logic [RW+SW-1:0]                w_prod;
    logic signed [VW-1:0]            w_q, w_v;
    logic [SW-1:0]                   w_clamped;
    logic [tpam_pkg::TIME_W-1:0]     w_elapsed;

    tpam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load_out  = (r_state == S_EMIT) && w_out_free;
    assign w_count_inc = {1'b0, r_count} + 1'b1;

    assign w_avg_sum  = (r_state == S_AVG_Y) ? r_sum_y : r_sum_x;
    assign w_avg_prod = {{tpam_pkg::RECIP_W{1'b0}}, w_avg_sum} *
                        {{tpam_pkg::SUM_W{1'b0}}, tpam_pkg::AVG_RECIP};
    assign w_avg      = w_avg_prod[tpam_pkg::AVG_SHIFT +: RW];

    assign w_wm1 = (r_width == '0) ? '0 :
                   (r_width > tpam_pkg::SIZE_MAX) ? SW'(tpam_pkg::SIZE_MAX - 1'b1) :
                   SW'(r_width - 1'b1);
    assign w_hm1 = (r_height == '0) ? '0 :
                   (r_height > tpam_pkg::SIZE_MAX) ? SW'(tpam_pkg::SIZE_MAX - 1'b1) :
                   SW'(r_height - 1'b1);

    // Screen x comes from averaged Y inverted, screen y from averaged X.
    assign m_raw       = r_axis ? r_ax : r_ay;
    assign m_lo        = r_axis ? r_x_lo : r_y_lo;
    assign m_hi        = r_axis ? r_x_hi : r_y_hi;
    assign m_dm        = r_axis ? w_hm1 : w_wm1;
    assign m_base      = r_axis ? '0 : w_wm1;
    assign m_delta_neg = !r_axis;

    assign w_diff     = {1'b0, m_raw} - {1'b0, m_lo};
    assign w_diff_abs = w_diff[RW] ? ((RW+1)'(0) - w_diff) : w_diff;
    assign w_span     = {1'b0, m_hi} - {1'b0, m_lo};
    assign w_span_abs = w_span[RW] ? ((RW+1)'(0) - w_span) : w_span;
    assign w_prod     = w_diff_abs[RW-1:0] * m_dm;

    always_comb begin
        w_q = $signed({2'b00, w_rsp.quot});
        if (r_zero) begin
            w_v = '0;
        end else begin
            w_v = $signed({{(VW-SW){1'b0}}, m_base}) + (r_neg ? -w_q : w_q);
        end
        if (w_v < 0) begin
            w_clamped = '0;
        end else if (w_v > $signed({{(VW-SW){1'b0}}, m_dm})) begin
            w_clamped = m_dm;
        end else begin
            w_clamped = w_v[SW-1:0];
        end
    end

    assign w_elapsed = r_now - r_last;

    always_comb begin
        w_req.start    = (r_state == S_MAP_GO);
        w_req.dividend = r_prod;
        w_req.divisor  = r_span;
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_count     = r_count;
        n_last      = r_last;
        n_now       = r_now;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_px        = r_px;
        n_py        = r_py;
        n_pressed   = r_pressed;
        n_tap       = r_tap;
        n_prod      = r_prod;
        n_span      = r_span;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;

        if (w_out_free) begin
            n_out_valid = (r_state == S_EMIT);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((r_count == '0) && !i_pen_down) begin
                        n_pressed = 1'b0;
                        n_tap     = 1'b0;
                        n_px      = '0;
                        n_py      = '0;
                        n_ax      = '0;
                        n_ay      = '0;
                        n_state   = S_EMIT;
                    end else begin
                        n_sum_x = r_sum_x + {{(tpam_pkg::SUM_W-RW){1'b0}}, i_sample_x};
                        n_sum_y = r_sum_y + {{(tpam_pkg::SUM_W-RW){1'b0}}, i_sample_y};
                        if (w_count_inc <
                            (tpam_pkg::CNT_W+1)'(tpam_pkg::SAMPLES_PER_READ)) begin
                            n_count = w_count_inc[tpam_pkg::CNT_W-1:0];
                        end else begin
                            n_count = '0;
                            n_now   = i_now_ms;
                            n_state = S_AVG_X;
                        end
                    end
                end
            end
            S_AVG_X: begin
                n_ax    = w_avg;
                n_state = S_AVG_Y;
            end
            S_AVG_Y: begin
                n_ay    = w_avg;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_sum_x = '0;
                n_sum_y = '0;
                n_axis  = 1'b0;
                if ((r_ax < r_floor) || (r_ay < r_floor)) begin
                    n_pressed = 1'b0;
                    n_tap     = 1'b0;
                    n_px      = '0;
                    n_py      = '0;
                    n_state   = S_EMIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {1'b0, w_prod};
                n_span  = w_span_abs[RW-1:0];
                n_neg   = w_diff[RW] ^ m_delta_neg ^ w_span[RW];
                n_zero  = (w_span == '0);
                n_state = S_MAP_GO;
            end
            S_MAP_GO: begin
                n_state = S_MAP_WAIT;
            end
            S_MAP_WAIT: begin
                if (w_rsp.done) begin
                    if (!r_axis) begin
                        n_px    = w_clamped;
                        n_axis  = 1'b1;
                        n_state = S_MUL;
                    end else begin
                        n_py    = w_clamped;
                        n_state = S_TAP;
                    end
                end
            end
            S_TAP: begin
                n_pressed = 1'b1;
                n_tap     = 1'b0;
                if (w_elapsed >= {{(tpam_pkg::TIME_W-tpam_pkg::DEB_W){1'b0}}, r_deb}) begin
                    n_tap  = 1'b1;
                    n_last = r_now;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_x_lo      <= tpam_pkg::X_RAW_LOW_RST;
            r_x_hi      <= tpam_pkg::X_RAW_HIGH_RST;
            r_y_lo      <= tpam_pkg::Y_RAW_LOW_RST;
            r_y_hi      <= tpam_pkg::Y_RAW_HIGH_RST;
            r_width     <= tpam_pkg::WIDTH_RST;
            r_height    <= tpam_pkg::HEIGHT_RST;
            r_floor     <= tpam_pkg::FLOOR_RST;
            r_deb       <= tpam_pkg::DEBOUNCE_RST;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_count     <= n_count;
            r_last      <= n_last;
            r_now       <= n_now;
            r_ax        <= n_ax;
            r_ay        <= n_ay;
            r_px        <= n_px;
            r_py        <= n_py;
            r_pressed   <= n_pressed;
            r_tap       <= n_tap;
            r_prod      <= n_prod;
            r_span      <= n_span;
            r_neg       <= n_neg;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
            if (w_load_out) begin
                r_o_pressed <= r_pressed;
                r_o_tapped  <= r_tap;
                r_o_px      <= r_px;
                r_o_py      <= r_py;
                r_o_ax      <= r_ax;
                r_o_ay      <= r_ay;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tpam_pkg::CFG_X_RAW_LOW:   r_x_lo   <= i_cfg_data[RW-1:0];
                    tpam_pkg::CFG_X_RAW_HIGH:  r_x_hi   <= i_cfg_data[RW-1:0];
                    tpam_pkg::CFG_Y_RAW_LOW:   r_y_lo   <= i_cfg_data[RW-1:0];
                    tpam_pkg::CFG_Y_RAW_HIGH:  r_y_hi   <= i_cfg_data[RW-1:0];
                    tpam_pkg::CFG_SCR_WIDTH:   r_width  <= i_cfg_data[tpam_pkg::SIZE_W-1:0];
                    tpam_pkg::CFG_SCR_HEIGHT:  r_height <= i_cfg_data[tpam_pkg::SIZE_W-1:0];
                    tpam_pkg::CFG_PRESS_FLOOR: r_floor  <= i_cfg_data[RW-1:0];
                    tpam_pkg::CFG_DEBOUNCE:    r_deb    <= i_cfg_data[tpam_pkg::DEB_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pressed   = r_o_pressed;
    assign o_tapped    = r_o_tapped;
    assign o_screen_x  = r_o_px;
    assign o_screen_y  = r_o_py;
    assign o_avg_x     = r_o_ax;
    assign o_avg_y     = r_o_ay;

endmodule
